// File: rtl/core/cbts_pkg.sv
// Shared types, codes and field step functions of the calendar button time setter.
`timescale 1ns / 1ps

package cbts_pkg;

	localparam logic KIND_POLL = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic CFG_SLEEP_LIMIT     = 1'b0;
	localparam logic CFG_EDIT_HOLD_LIMIT = 1'b1;

	localparam int PIN_RTC   = 0;
	localparam int PIN_UP    = 1;
	localparam int PIN_DOWN  = 2;
	localparam int PIN_LEFT  = 3;
	localparam int PIN_RIGHT = 4;

	localparam logic [2:0] FIELD_YEAR   = 3'd0;
	localparam logic [2:0] FIELD_MONTH  = 3'd1;
	localparam logic [2:0] FIELD_DAY    = 3'd2;
	localparam logic [2:0] FIELD_HOUR   = 3'd3;
	localparam logic [2:0] FIELD_MINUTE = 3'd4;
	localparam logic [2:0] FIELD_SECOND = 3'd5;

	localparam logic [3:0] MONTH_MAX  = 4'd12;
	localparam logic [5:0] DAY_MAX    = 6'd31;
	localparam logic [5:0] HOUR_MAX   = 6'd23;
	localparam logic [5:0] MINSEC_MAX = 6'd59;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	localparam logic [15:0] SLEEP_LIMIT_RESET     = 16'd10;
	localparam logic [15:0] EDIT_HOLD_LIMIT_RESET = 16'd3;

	typedef struct packed {
		logic       kind;
		logic [4:0] levels;
		logic [7:0] rtc_year;
		logic [3:0] rtc_month;
	} item_t;

	typedef struct packed {
		logic        commit;
		logic        redraw;
	} flags_t;

	typedef struct packed {
		logic [4:0]  prev_levels;
		logic [15:0] idle;
		logic [15:0] hold;
		logic        edit_on;
		logic [2:0]  cursor;
		logic [7:0]  year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [3:0]  page_month;
		logic [15:0] page_year;
		logic        sleep;
	} ctrl_state_t;

	localparam ctrl_state_t STATE_RESET = '{
		prev_levels: 5'd0,
		idle:        16'd0,
		hold:        16'd0,
		edit_on:     1'b0,
		cursor:      FIELD_YEAR,
		year:        8'd24,
		month:       4'd10,
		day:         5'd1,
		hour:        5'd10,
		minute:      6'd0,
		second:      6'd0,
		page_month:  4'd0,
		page_year:   16'd0,
		sleep:       1'b0
	};

	function automatic logic [5:0] wrap_inc(input logic [5:0] v, input logic [5:0] lo,
		input logic [5:0] hi);
		return (v < hi) ? v + 6'd1 : lo;
	endfunction

	function automatic logic [5:0] wrap_dec(input logic [5:0] v, input logic [5:0] lo,
		input logic [5:0] hi);
		return (v > lo) ? v - 6'd1 : hi;
	endfunction

endpackage

// File: rtl/core/cbts_next.sv
// Next-state and result flag logic for one poll or tick word.
`timescale 1ns / 1ps

module cbts_next import cbts_pkg::*; (
	input  item_t       item,
	input  ctrl_state_t cur,
	input  logic [15:0] sleep_limit,
	input  logic [15:0] edit_hold_limit,
	output ctrl_state_t nxt,
	output flags_t      flags
);

	logic [4:0] rise;

	always_comb begin
		nxt = cur;
		flags = '0;
		rise = item.levels & ~cur.prev_levels;
		if (item.kind == KIND_POLL) begin
			if (rise[PIN_RTC]) begin
				if (nxt.edit_on) begin
					flags.commit = 1'b1;
					nxt.edit_on = 1'b0;
				end else begin
					nxt.page_month = item.rtc_month;
					nxt.page_year = {8'd0, item.rtc_year};
				end
			end
			// The down switch steps forward, the up switch steps back.
			if (rise[PIN_DOWN]) begin
				if (nxt.edit_on) begin
					unique case (nxt.cursor)
						FIELD_YEAR:   nxt.year = nxt.year + 8'd1;
						FIELD_MONTH:  nxt.month = 4'(wrap_inc({2'd0, nxt.month}, 6'd1,
							{2'd0, MONTH_MAX}));
						FIELD_DAY:    nxt.day = 5'(wrap_inc({1'b0, nxt.day}, 6'd1, DAY_MAX));
						FIELD_HOUR:   nxt.hour = 5'(wrap_inc({1'b0, nxt.hour}, 6'd0, HOUR_MAX));
						FIELD_MINUTE: nxt.minute = wrap_inc(nxt.minute, 6'd0, MINSEC_MAX);
						FIELD_SECOND: nxt.second = wrap_inc(nxt.second, 6'd0, MINSEC_MAX);
						default: ;
					endcase
				end else if (nxt.page_month >= MONTH_MAX) begin
					nxt.page_month = 4'd1;
					nxt.page_year = nxt.page_year + 16'd1;
				end else begin
					nxt.page_month = nxt.page_month + 4'd1;
				end
			end
			if (rise[PIN_UP]) begin
				if (nxt.edit_on) begin
					unique case (nxt.cursor)
						FIELD_YEAR:   nxt.year = nxt.year - 8'd1;
						FIELD_MONTH:  nxt.month = 4'(wrap_dec({2'd0, nxt.month}, 6'd1,
							{2'd0, MONTH_MAX}));
						FIELD_DAY:    nxt.day = 5'(wrap_dec({1'b0, nxt.day}, 6'd1, DAY_MAX));
						FIELD_HOUR:   nxt.hour = 5'(wrap_dec({1'b0, nxt.hour}, 6'd0, HOUR_MAX));
						FIELD_MINUTE: nxt.minute = wrap_dec(nxt.minute, 6'd0, MINSEC_MAX);
						FIELD_SECOND: nxt.second = wrap_dec(nxt.second, 6'd0, MINSEC_MAX);
						default: ;
					endcase
				end else if (nxt.page_month <= 4'd1) begin
					nxt.page_month = MONTH_MAX;
					nxt.page_year = nxt.page_year - 16'd1;
				end else begin
					nxt.page_month = nxt.page_month - 4'd1;
				end
			end
			if (rise[PIN_LEFT] && nxt.edit_on && nxt.cursor > FIELD_YEAR) begin
				nxt.cursor = nxt.cursor - 3'd1;
			end
			if (rise[PIN_RIGHT] && nxt.edit_on && nxt.cursor < FIELD_SECOND) begin
				nxt.cursor = nxt.cursor + 3'd1;
			end
			if (rise != 5'd0) begin
				nxt.idle = 16'd0;
				flags.redraw = 1'b1;
			end
			nxt.prev_levels = item.levels;
		end else begin
			if (nxt.idle != COUNT_MAX) begin
				nxt.idle = nxt.idle + 16'd1;
			end
			if (nxt.idle > sleep_limit) begin
				nxt.page_month = item.rtc_month;
				nxt.page_year = {8'd0, item.rtc_year};
				nxt.sleep = 1'b1;
				flags.redraw = 1'b1;
			end
			if (!item.levels[PIN_LEFT] || !item.levels[PIN_RIGHT]) begin
				if (nxt.hold != COUNT_MAX) begin
					nxt.hold = nxt.hold + 16'd1;
				end
			end else begin
				nxt.hold = 16'd0;
			end
			if (nxt.hold > edit_hold_limit) begin
				nxt.edit_on = 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/calendar_button_time_setter_unit.sv
// Top level of the calendar button time setter: handshakes, state and result register.
//
//  channel   direction  handshake                     payload
//  item      in         item_valid / item_stall       kind, pin levels, rtc_year, rtc_month
//  result    out        result_valid / result_stall   edit values, view page, commit, status
//  config    in         wr_en, wr_index               wr_data (16 bits)
//
// An accepted word passes through the input register and then through the update logic
// into the state and result registers. One word can be accepted every cycle unless the
// result stalls; the state update is a single pass.
// Reset brings back the power-on edit values and the default limits at once.
// A stalled result holds the state, and the input register then stalls the item side.
`timescale 1ns / 1ps

module calendar_button_time_setter_unit import cbts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [15:0]        wr_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               kind,
	input  logic               rtc_int_level,
	input  logic               up_level,
	input  logic               down_level,
	input  logic               left_level,
	input  logic               right_level,
	input  logic [7:0]         rtc_year,
	input  logic [3:0]         rtc_month,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               edit_active,
	output logic [2:0]         edit_cursor,
	output logic [7:0]         set_year,
	output logic [3:0]         set_month,
	output logic [4:0]         set_day,
	output logic [4:0]         set_hour,
	output logic [5:0]         set_minute,
	output logic [5:0]         set_second,
	output logic [3:0]         view_month,
	output logic signed [15:0] view_year,
	output logic               commit_pulse,
	output logic [1:0]         status_flags
);

	logic        sleep_limit_wr;
	logic [15:0] sleep_limit_val_q;
	logic [15:0] edit_hold_limit_q;
	logic        valid_s1;
	item_t       item_s1;
	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	flags_t      flags_nxt;
	flags_t      flags_q;
	logic        accept;
	logic        advance;

	assign sleep_limit_wr = wr_en && (wr_index == CFG_SLEEP_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_limit_val_q <= SLEEP_LIMIT_RESET;
			edit_hold_limit_q <= EDIT_HOLD_LIMIT_RESET;
		end else if (sleep_limit_wr) begin
			sleep_limit_val_q <= wr_data;
		end else if (wr_en && wr_index == CFG_EDIT_HOLD_LIMIT) begin
			edit_hold_limit_q <= wr_data;
		end
	end

	assign advance = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{kind: kind,
				levels: {right_level, left_level, down_level, up_level, rtc_int_level},
				rtc_year: rtc_year, rtc_month: rtc_month};
		end
	end

	cbts_next u_next (
		.item            (item_s1),
		.cur             (state_q),
		.sleep_limit     (sleep_limit_val_q),
		.edit_hold_limit (edit_hold_limit_q),
		.nxt             (state_nxt),
		.flags           (flags_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			flags_q <= '0;
			result_valid <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
			flags_q <= flags_nxt;
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	assign edit_active  = state_q.edit_on;
	assign edit_cursor  = state_q.cursor;
	assign set_year     = state_q.year;
	assign set_month    = state_q.month;
	assign set_day      = state_q.day;
	assign set_hour     = state_q.hour;
	assign set_minute   = state_q.minute;
	assign set_second   = state_q.second;
	assign view_month   = state_q.page_month;
	assign view_year    = signed'(state_q.page_year);
	assign commit_pulse = flags_q.commit;
	assign status_flags = {state_q.sleep, flags_q.redraw};

	// The cursor never leaves the range of edit fields.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cursor <= FIELD_SECOND)
		else $error("edit cursor out of range");

	// A commit always leaves edit mode in the same word.
	a_commit_leaves_edit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && commit_pulse |-> !edit_active)
		else $error("commit with edit mode still on");

	// State moves only when a word passes into the result register.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a word");

	// The sleep request is sticky until reset.
	a_sleep_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.sleep |=> state_q.sleep)
		else $error("sleep request dropped");

endmodule

// File: bench/calendar_button_time_setter_unit_test.sv
// Self-checking testbench of the calendar button time setter with a scoreboard class.
`timescale 1ns / 1ps

module calendar_button_time_setter_unit_test;
	import cbts_pkg::*;

	typedef struct packed {
		logic        edit_active;
		logic [2:0]  edit_cursor;
		logic [7:0]  set_year;
		logic [3:0]  set_month;
		logic [4:0]  set_day;
		logic [4:0]  set_hour;
		logic [5:0]  set_minute;
		logic [5:0]  set_second;
		logic [3:0]  view_month;
		logic [15:0] view_year;
		logic        commit_pulse;
		logic [1:0]  status_flags;
	} panel_t;

	class panel_scoreboard;
		logic [15:0] sleep_limit;
		logic [15:0] hold_limit;
		logic [4:0]  prev_levels;
		logic [15:0] idle_secs;
		logic [15:0] hold_secs;
		logic        edit_on;
		logic [2:0]  cursor;
		logic [7:0]  year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [3:0]  page_month;
		logic [15:0] page_year;
		logic        sleep_req;
		panel_t      panel_q[$];
		int unsigned errors;

		function new();
			sleep_limit = SLEEP_LIMIT_RESET;
			hold_limit = EDIT_HOLD_LIMIT_RESET;
			prev_levels = '0;
			idle_secs = '0;
			hold_secs = '0;
			edit_on = 1'b0;
			cursor = FIELD_YEAR;
			year = 8'd24;
			month = 4'd10;
			day = 5'd1;
			hour = 5'd10;
			minute = '0;
			second = '0;
			page_month = '0;
			page_year = '0;
			sleep_req = 1'b0;
			errors = 0;
		endfunction

		function void set_limit(logic idx, logic [15:0] v);
			if (idx == CFG_SLEEP_LIMIT) begin
				sleep_limit = v;
			end else begin
				hold_limit = v;
			end
		endfunction

		function int unsigned pending();
			return panel_q.size();
		endfunction

		function void step_field(bit raise);
			case (cursor)
				FIELD_YEAR: begin
					year = raise ? year + 8'd1 : year - 8'd1;
				end
				FIELD_MONTH: begin
					if (raise) begin
						month = (month < MONTH_MAX) ? month + 4'd1 : 4'd1;
					end else begin
						month = (month > 4'd1) ? month - 4'd1 : MONTH_MAX;
					end
				end
				FIELD_DAY: begin
					if (raise) begin
						day = (day < DAY_MAX) ? day + 5'd1 : 5'd1;
					end else begin
						day = (day > 5'd1) ? day - 5'd1 : 5'(DAY_MAX);
					end
				end
				FIELD_HOUR: begin
					if (raise) begin
						hour = (hour < HOUR_MAX) ? hour + 5'd1 : 5'd0;
					end else begin
						hour = (hour > 5'd0) ? hour - 5'd1 : 5'(HOUR_MAX);
					end
				end
				FIELD_MINUTE: begin
					if (raise) begin
						minute = (minute < MINSEC_MAX) ? minute + 6'd1 : 6'd0;
					end else begin
						minute = (minute > 6'd0) ? minute - 6'd1 : MINSEC_MAX;
					end
				end
				FIELD_SECOND: begin
					if (raise) begin
						second = (second < MINSEC_MAX) ? second + 6'd1 : 6'd0;
					end else begin
						second = (second > 6'd0) ? second - 6'd1 : MINSEC_MAX;
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void note_word(item_t w);
			logic [4:0] rise;
			logic       commit;
			logic       redraw;
			panel_t     p;
			commit = 1'b0;
			redraw = 1'b0;
			if (w.kind == KIND_POLL) begin
				rise = w.levels & ~prev_levels;
				if (rise[PIN_RTC]) begin
					if (edit_on) begin
						commit = 1'b1;
						edit_on = 1'b0;
					end else begin
						page_month = w.rtc_month;
						page_year = {8'd0, w.rtc_year};
					end
				end
				if (rise[PIN_DOWN]) begin
					if (edit_on) begin
						step_field(1'b1);
					end else if (page_month >= MONTH_MAX) begin
						page_month = 4'd1;
						page_year = page_year + 16'd1;
					end else begin
						page_month = page_month + 4'd1;
					end
				end
				if (rise[PIN_UP]) begin
					if (edit_on) begin
						step_field(1'b0);
					end else if (page_month <= 4'd1) begin
						page_month = MONTH_MAX;
						page_year = page_year - 16'd1;
					end else begin
						page_month = page_month - 4'd1;
					end
				end
				if (rise[PIN_LEFT] && edit_on && cursor > FIELD_YEAR) begin
					cursor = cursor - 3'd1;
				end
				if (rise[PIN_RIGHT] && edit_on && cursor < FIELD_SECOND) begin
					cursor = cursor + 3'd1;
				end
				if (rise != 5'd0) begin
					idle_secs = '0;
					redraw = 1'b1;
				end
				prev_levels = w.levels;
			end else begin
				if (idle_secs != COUNT_MAX) begin
					idle_secs = idle_secs + 16'd1;
				end
				if (idle_secs > sleep_limit) begin
					page_month = w.rtc_month;
					page_year = {8'd0, w.rtc_year};
					redraw = 1'b1;
					sleep_req = 1'b1;
				end
				if (!w.levels[PIN_LEFT] || !w.levels[PIN_RIGHT]) begin
					if (hold_secs != COUNT_MAX) begin
						hold_secs = hold_secs + 16'd1;
					end
				end else begin
					hold_secs = '0;
				end
				if (hold_secs > hold_limit) begin
					edit_on = 1'b1;
				end
			end
			p.edit_active = edit_on;
			p.edit_cursor = cursor;
			p.set_year = year;
			p.set_month = month;
			p.set_day = day;
			p.set_hour = hour;
			p.set_minute = minute;
			p.set_second = second;
			p.view_month = page_month;
			p.view_year = page_year;
			p.commit_pulse = commit;
			p.status_flags = {sleep_req, redraw};
			panel_q.push_back(p);
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_panel(panel_t got);
			panel_t want;
			if (panel_q.size() == 0) begin
				$error("result word arrived with no expected word");
				errors++;
				return;
			end
			want = panel_q.pop_front();
			check_field("edit_active", 16'(want.edit_active), 16'(got.edit_active));
			check_field("edit_cursor", 16'(want.edit_cursor), 16'(got.edit_cursor));
			check_field("set_year", 16'(want.set_year), 16'(got.set_year));
			check_field("set_month", 16'(want.set_month), 16'(got.set_month));
			check_field("set_day", 16'(want.set_day), 16'(got.set_day));
			check_field("set_hour", 16'(want.set_hour), 16'(got.set_hour));
			check_field("set_minute", 16'(want.set_minute), 16'(got.set_minute));
			check_field("set_second", 16'(want.set_second), 16'(got.set_second));
			check_field("view_month", 16'(want.view_month), 16'(got.view_month));
			check_field("view_year", want.view_year, got.view_year);
			check_field("commit_pulse", 16'(want.commit_pulse), 16'(got.commit_pulse));
			check_field("status_flags", 16'(want.status_flags), 16'(got.status_flags));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	logic               wr_index = 1'b0;
	logic [15:0]        wr_data = '0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic               kind = 1'b0;
	logic               rtc_int_level = 1'b0;
	logic               up_level = 1'b0;
	logic               down_level = 1'b0;
	logic               left_level = 1'b0;
	logic               right_level = 1'b0;
	logic [7:0]         rtc_year = '0;
	logic [3:0]         rtc_month = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic               edit_active;
	logic [2:0]         edit_cursor;
	logic [7:0]         set_year;
	logic [3:0]         set_month;
	logic [4:0]         set_day;
	logic [4:0]         set_hour;
	logic [5:0]         set_minute;
	logic [5:0]         set_second;
	logic [3:0]         view_month;
	logic signed [15:0] view_year;
	logic               commit_pulse;
	logic [1:0]         status_flags;

	panel_scoreboard sb;
	int unsigned     gap_pct = 30;
	int unsigned     stall_pct = 30;
	logic [4:0]      cur_levels = '0;

	calendar_button_time_setter_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.kind          (kind),
		.rtc_int_level (rtc_int_level),
		.up_level      (up_level),
		.down_level    (down_level),
		.left_level    (left_level),
		.right_level   (right_level),
		.rtc_year      (rtc_year),
		.rtc_month     (rtc_month),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.edit_active   (edit_active),
		.edit_cursor   (edit_cursor),
		.set_year      (set_year),
		.set_month     (set_month),
		.set_day       (set_day),
		.set_hour      (set_hour),
		.set_minute    (set_minute),
		.set_second    (set_second),
		.view_month    (view_month),
		.view_year     (view_year),
		.commit_pulse  (commit_pulse),
		.status_flags  (status_flags)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		panel_t got;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			got.edit_active = edit_active;
			got.edit_cursor = edit_cursor;
			got.set_year = set_year;
			got.set_month = set_month;
			got.set_day = set_day;
			got.set_hour = set_hour;
			got.set_minute = set_minute;
			got.set_second = set_second;
			got.view_month = view_month;
			got.view_year = view_year;
			got.commit_pulse = commit_pulse;
			got.status_flags = status_flags;
			sb.check_panel(got);
		end
	end

	function automatic logic [4:0] pins(int rint, int up, int down, int left, int right);
		logic [4:0] lv;
		lv[PIN_RTC] = rint[0];
		lv[PIN_UP] = up[0];
		lv[PIN_DOWN] = down[0];
		lv[PIN_LEFT] = left[0];
		lv[PIN_RIGHT] = right[0];
		return lv;
	endfunction

	task automatic send_item(input logic k, input logic [4:0] lv, input logic [7:0] ry,
		input logic [3:0] rm);
		item_t w;
		w.kind = k;
		w.levels = lv;
		w.rtc_year = ry;
		w.rtc_month = rm;
		if ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		kind <= k;
		rtc_int_level <= lv[PIN_RTC];
		up_level <= lv[PIN_UP];
		down_level <= lv[PIN_DOWN];
		left_level <= lv[PIN_LEFT];
		right_level <= lv[PIN_RIGHT];
		rtc_year <= ry;
		rtc_month <= rm;
		do @(posedge clk); while (item_stall !== 1'b0);
		sb.note_word(w);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input logic idx, input logic [15:0] v);
		wait_drained();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		@(negedge clk);
		wr_en <= 1'b0;
		sb.set_limit(idx, v);
	endtask

	task automatic random_month(output logic [3:0] rm);
		rm = ($urandom_range(99) < 85) ? 4'($urandom_range(1, 12)) : 4'($urandom_range(15));
	endtask

	task automatic random_phase(input int n);
		int         i;
		int         r;
		int         ticks;
		logic [3:0] rm;
		logic [4:0] lv;
		i = 0;
		while (i < n) begin
			r = $urandom_range(99);
			random_month(rm);
			if ($urandom_range(149) == 0) begin
				wait_drained();
			end
			if (r < 10) begin
				// Press and hold left or right across one or more ticks, then let go.
				if ($urandom_range(1)) begin
					cur_levels[PIN_LEFT] = 1'b0;
				end else begin
					cur_levels[PIN_RIGHT] = 1'b0;
				end
				send_item(KIND_POLL, cur_levels, 8'($urandom), rm);
				ticks = (sb.hold_limit < 6) ? sb.hold_limit + 1 + $urandom_range(1)
					: $urandom_range(1, 4);
				repeat (ticks) send_item(KIND_TICK, cur_levels, 8'($urandom), rm);
				cur_levels[PIN_LEFT] = 1'b1;
				cur_levels[PIN_RIGHT] = 1'b1;
				send_item(KIND_POLL, cur_levels, 8'($urandom), rm);
				i += ticks + 2;
			end else if (r < 45) begin
				lv = cur_levels;
				if ($urandom_range(4) == 0) begin
					lv = 5'($urandom);
				end
				send_item(KIND_TICK, lv, 8'($urandom), rm);
				i++;
			end else if (r < 55) begin
				cur_levels = 5'($urandom);
				send_item(KIND_POLL, cur_levels, 8'($urandom), rm);
				i++;
			end else begin
				cur_levels[3'($urandom_range(4))] ^= 1'b1;
				if ($urandom_range(3) == 0) begin
					cur_levels[3'($urandom_range(4))] ^= 1'b1;
				end
				send_item(KIND_POLL, cur_levels, 8'($urandom), rm);
				i++;
			end
		end
	endtask

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		send_item(KIND_POLL, pins(1, 0, 0, 0, 0), 8'd255, 4'd12);
		send_item(KIND_POLL, pins(0, 0, 1, 0, 0), 8'd0, 4'd1);
		send_item(KIND_POLL, pins(1, 1, 0, 0, 0), 8'd0, 4'd0);
		send_item(KIND_POLL, pins(0, 0, 1, 0, 0), 8'd0, 4'd1);
		send_item(KIND_POLL, pins(1, 0, 0, 0, 0), 8'd7, 4'd15);
		send_item(KIND_POLL, pins(0, 0, 1, 0, 0), 8'd7, 4'd15);
		send_item(KIND_POLL, pins(1, 0, 0, 0, 0), 8'd9, 4'd13);
		send_item(KIND_POLL, pins(0, 1, 0, 0, 0), 8'd9, 4'd13);
		repeat (4) send_item(KIND_TICK, pins(0, 1, 0, 0, 1), 8'd1, 4'd2);
		send_item(KIND_POLL, pins(0, 0, 0, 0, 0), 8'd1, 4'd2);
		send_item(KIND_POLL, pins(0, 1, 0, 0, 0), 8'd1, 4'd2);
		send_item(KIND_POLL, pins(0, 0, 0, 1, 0), 8'd1, 4'd2);
		repeat (5) begin
			send_item(KIND_POLL, pins(0, 0, 0, 0, 0), 8'd1, 4'd2);
			send_item(KIND_POLL, pins(0, 0, 0, 0, 1), 8'd1, 4'd2);
		end
		send_item(KIND_POLL, pins(0, 1, 0, 0, 0), 8'd1, 4'd2);
		send_item(KIND_POLL, pins(0, 0, 1, 0, 0), 8'd1, 4'd2);
		send_item(KIND_POLL, pins(0, 0, 0, 0, 0), 8'd1, 4'd2);
		send_item(KIND_POLL, pins(1, 0, 1, 0, 1), 8'd1, 4'd2);
		cur_levels = pins(1, 0, 1, 0, 1);

		gap_pct = 0;
		stall_pct = 0;
		random_phase(300);
		gap_pct = 30;
		stall_pct = 30;

		write_limit(CFG_SLEEP_LIMIT, 16'd0);
		write_limit(CFG_EDIT_HOLD_LIMIT, 16'd0);
		random_phase(300);

		write_limit(CFG_SLEEP_LIMIT, 16'd2);
		write_limit(CFG_EDIT_HOLD_LIMIT, 16'd1);
		random_phase(300);

		write_limit(CFG_SLEEP_LIMIT, 16'($urandom_range(12)));
		write_limit(CFG_EDIT_HOLD_LIMIT, 16'($urandom_range(6)));
		random_phase(300);

		write_limit(CFG_SLEEP_LIMIT, COUNT_MAX);
		write_limit(CFG_EDIT_HOLD_LIMIT, COUNT_MAX);
		random_phase(300);

		write_limit(CFG_SLEEP_LIMIT, SLEEP_LIMIT_RESET);
		write_limit(CFG_EDIT_HOLD_LIMIT, EDIT_HOLD_LIMIT_RESET);
		random_phase(100);

		wait_drained();
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
